>>> rtl/core/fbr_pkg.sv
// Package for the framed byte receiver: phase and result codes, result bundle,
// and the byte-wide CRC-8 update. No dependencies.
package fbr_pkg;

    localparam logic [7:0] SYNC_FIRST        = 8'h55;
    localparam logic [7:0] SYNC_SECOND       = 8'hAA;
    localparam logic [7:0] CRC_POLY          = 8'h07;
    localparam logic [7:0] CRC_TOPBIT        = 8'h80;
    localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd200;

    typedef enum logic [2:0] {
        PH_HUNT0 = 3'd0,
        PH_HUNT1 = 3'd1,
        PH_LEN   = 3'd2,
        PH_CMD   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CRC   = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_CRC_ERR = 2'd2,
        KIND_LEN_ERR = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  frame_cmd;
        logic [7:0]  frame_len;
        logic [7:0]  data_byte;
        logic [7:0]  data_index;
        logic [31:0] good_total;
        logic [31:0] crc_fail_total;
    } t_result;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOPBIT) != 8'd0) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/core/framed_byte_receiver_crc8.sv
// Framed byte receiver with CRC-8 check: top level.
// A result is registered (output or skid entry) when the byte that causes it is taken.
// Throughput: one byte per cycle; the input stalls only when the result
// register and its skid entry are both full.
// Reset (synchronous, active low): hunt for the first sync byte, counters and
// CRC cleared, length limit back to 200. Depends on fbr_pkg, fbr_deframer, fbr_out_stage.
module framed_byte_receiver_crc8 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_frame_cmd,
    output logic [7:0]  o_frame_len,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_data_index,
    output logic [31:0] o_good_total,
    output logic [31:0] o_crc_fail_total
);
    import fbr_pkg::*;

    logic    take;
    logic    res_valid;
    logic    full;
    t_result res;
    t_result out_res;

    assign o_stall = full;
    assign take    = i_valid && !full;

    fbr_deframer u_deframer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_rx_byte     (i_rx_byte),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    fbr_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_stall     (i_stall),
        .o_full      (full),
        .o_valid     (o_valid),
        .o_res       (out_res)
    );

    assign o_kind           = out_res.kind;
    assign o_frame_cmd      = out_res.frame_cmd;
    assign o_frame_len      = out_res.frame_len;
    assign o_data_byte      = out_res.data_byte;
    assign o_data_index     = out_res.data_index;
    assign o_good_total     = out_res.good_total;
    assign o_crc_fail_total = out_res.crc_fail_total;

endmodule

>>> rtl/core/fbr_deframer.sv
// Frame parser: phase register, CRC, frame fields, good and CRC-failure counters and
// the length limit register. Depends on fbr_pkg.
module fbr_deframer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic [7:0]      i_rx_byte,
    input  logic            i_cfg_wr_en,
    input  logic [7:0]      i_cfg_wr_data,
    output logic            o_res_valid,
    output fbr_pkg::t_result o_res
);
    import fbr_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_cmd, n_cmd;
    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [31:0] r_good, n_good;
    logic [31:0] r_fail, n_fail;
    logic [7:0]  r_max_payload;
    logic [7:0]  crc_next;

    assign crc_next = crc8_update((r_phase == PH_LEN) ? 8'd0 : r_crc, i_rx_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT0;
            r_len         <= 8'd0;
            r_cmd         <= 8'd0;
            r_pos         <= 8'd0;
            r_crc         <= 8'd0;
            r_good        <= 32'd0;
            r_fail        <= 32'd0;
            r_max_payload <= MAX_PAYLOAD_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_payload <= i_cfg_wr_data;
            end
            if (i_take) begin
                r_phase <= n_phase;
                r_len   <= n_len;
                r_cmd   <= n_cmd;
                r_pos   <= n_pos;
                r_crc   <= n_crc;
                r_good  <= n_good;
                r_fail  <= n_fail;
            end
        end
    end

    always_comb begin
        n_phase     = PH_HUNT0;
        n_len       = r_len;
        n_cmd       = r_cmd;
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_good      = r_good;
        n_fail      = r_fail;
        o_res_valid = 1'b0;
        o_res.kind       = KIND_PAYLOAD;
        o_res.frame_cmd  = r_cmd;
        o_res.frame_len  = r_len;
        o_res.data_byte  = 8'd0;
        o_res.data_index = 8'd0;
        unique case (r_phase)
            PH_HUNT1: begin
                n_phase = (i_rx_byte == SYNC_SECOND) ? PH_LEN : PH_HUNT0;
            end
            PH_LEN: begin
                n_len = i_rx_byte;
                n_pos = 8'd0;
                n_crc = crc_next;
                if (i_rx_byte > r_max_payload) begin
                    n_phase          = PH_HUNT0;
                    o_res_valid      = i_take;
                    o_res.kind       = KIND_LEN_ERR;
                    o_res.frame_cmd  = 8'd0;
                    o_res.frame_len  = i_rx_byte;
                end else begin
                    n_phase = PH_CMD;
                end
            end
            PH_CMD: begin
                n_cmd   = i_rx_byte;
                n_crc   = crc_next;
                n_phase = (r_len != 8'd0) ? PH_DATA : PH_CRC;
            end
            PH_DATA: begin
                n_crc   = crc_next;
                n_pos   = r_pos + 8'd1;
                n_phase = ({1'b0, r_pos} + 9'd1 >= {1'b0, r_len}) ? PH_CRC : PH_DATA;
                o_res_valid      = i_take;
                o_res.kind       = KIND_PAYLOAD;
                o_res.data_byte  = i_rx_byte;
                o_res.data_index = r_pos;
            end
            PH_CRC: begin
                n_phase     = PH_HUNT0;
                o_res_valid = i_take;
                if (i_rx_byte == r_crc) begin
                    n_good     = r_good + 32'd1;
                    o_res.kind = KIND_GOOD;
                end else begin
                    n_fail     = r_fail + 32'd1;
                    o_res.kind = KIND_CRC_ERR;
                end
            end
            default: begin
                n_phase = (i_rx_byte == SYNC_FIRST) ? PH_HUNT1 : PH_HUNT0;
            end
        endcase
        o_res.good_total     = n_good;
        o_res.crc_fail_total = n_fail;
    end

endmodule

>>> rtl/core/fbr_out_stage.sv
// Result register with one skid entry between the parser and the output
// channel. Depends on fbr_pkg.
module fbr_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_res_valid,
    input  fbr_pkg::t_result i_res,
    input  logic             i_stall,
    output logic             o_full,
    output logic             o_valid,
    output fbr_pkg::t_result o_res
);
    import fbr_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_res    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_res_valid;
            end
        end else if (i_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end else if (i_res_valid) begin
            r_skid <= i_res;
        end
    end

endmodule

>>> rtl/core/fbr_checker.sv
// Port-level checks for the framed byte receiver, bound to the top level.
// Depends on fbr_pkg and framed_byte_receiver_crc8.
module fbr_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_frame_cmd,
    input logic [7:0]  o_frame_len,
    input logic [7:0]  o_data_byte,
    input logic [7:0]  o_data_index
);
    import fbr_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("stalled result dropped");

    a_index_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_PAYLOAD |-> o_data_index < o_frame_len)
        else $error("payload index beyond declared length");

    a_verdict_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_PAYLOAD |-> o_data_byte == 8'd0 && o_data_index == 8'd0)
        else $error("data fields set on a verdict transaction");

    a_len_err_no_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_LEN_ERR |-> o_frame_cmd == 8'd0)
        else $error("command reported before it arrived");

endmodule

bind framed_byte_receiver_crc8 fbr_port_checks u_fbr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_kind       (o_kind),
    .o_frame_cmd  (o_frame_cmd),
    .o_frame_len  (o_frame_len),
    .o_data_byte  (o_data_byte),
    .o_data_index (o_data_index)
);

>>> test/fbr_checker.sv
// Scoreboard for the framed byte receiver: follows the sync, length, command,
// payload and CRC of every accepted byte, queues the expected results and
// compares each accepted result in order. Depends on fbr_pkg.
module fbr_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rx_valid,
    input  logic             i_rx_stall,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_cfg_wr_en,
    input  logic [7:0]       i_cfg_wr_data,
    input  logic             i_res_valid,
    input  logic             i_res_stall,
    input  fbr_pkg::t_result i_result,
    output int               o_pending,
    output int               o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import fbr_pkg::*;

    t_result     expected_q[$];
    t_phase      phase;
    logic [7:0]  max_len;
    logic [7:0]  declared_len;
    logic [7:0]  held_cmd;
    logic [7:0]  payload_pos;
    logic [7:0]  running_crc;
    logic [31:0] good_count;
    logic [31:0] crc_err_count;
    int          mismatches = 0;

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        repeat (8) c = {c[6:0], 1'b0} ^ (c[7] ? CRC_POLY : 8'h00);
        return c;
    endfunction

    always @(posedge i_clk) begin : track
        t_result    exp_r;
        t_result    fresh;
        logic       produced;
        logic [7:0] b;
        if (!i_rst_n) begin
            expected_q.delete();
            phase         = PH_HUNT0;
            max_len       = MAX_PAYLOAD_RESET;
            declared_len  = 8'h00;
            held_cmd      = 8'h00;
            payload_pos   = 8'h00;
            running_crc   = 8'h00;
            good_count    = 32'd0;
            crc_err_count = 32'd0;
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("fbr_checker: unexpected result kind=%0d cmd=%02h len=%0d",
                                 i_result.kind, i_result.frame_cmd, i_result.frame_len);
                    end
                end else begin
                    exp_r = expected_q.pop_front();
                    if (i_result.kind != exp_r.kind
                            || i_result.frame_cmd != exp_r.frame_cmd
                            || i_result.frame_len != exp_r.frame_len
                            || i_result.data_byte != exp_r.data_byte
                            || i_result.data_index != exp_r.data_index
                            || i_result.good_total != exp_r.good_total
                            || i_result.crc_fail_total != exp_r.crc_fail_total) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("fbr_checker: mismatch at %0t", $realtime);
                            $display({"  expected kind=%0d cmd=%02h len=%0d data=%02h",
                                      " idx=%0d good=%0d crcerr=%0d"},
                                     exp_r.kind, exp_r.frame_cmd, exp_r.frame_len,
                                     exp_r.data_byte, exp_r.data_index,
                                     exp_r.good_total, exp_r.crc_fail_total);
                            $display({"  actual   kind=%0d cmd=%02h len=%0d data=%02h",
                                      " idx=%0d good=%0d crcerr=%0d"},
                                     i_result.kind, i_result.frame_cmd, i_result.frame_len,
                                     i_result.data_byte, i_result.data_index,
                                     i_result.good_total, i_result.crc_fail_total);
                        end
                    end
                end
            end

            if (i_cfg_wr_en) begin
                max_len = i_cfg_wr_data;
            end

            if (i_rx_valid && !i_rx_stall) begin
                b        = i_rx_byte;
                produced = 1'b0;
                fresh    = '0;
                case (phase)
                    PH_HUNT1: begin
                        phase = (b == SYNC_SECOND) ? PH_LEN : PH_HUNT0;
                    end
                    PH_LEN: begin
                        declared_len = b;
                        payload_pos  = 8'h00;
                        running_crc  = crc8_next(8'h00, b);
                        if (b > max_len) begin
                            phase           = PH_HUNT0;
                            fresh.kind      = KIND_LEN_ERR;
                            fresh.frame_len = b;
                            produced        = 1'b1;
                        end else begin
                            phase = PH_CMD;
                        end
                    end
                    PH_CMD: begin
                        held_cmd    = b;
                        running_crc = crc8_next(running_crc, b);
                        phase       = (declared_len != 8'h00) ? PH_DATA : PH_CRC;
                    end
                    PH_DATA: begin
                        fresh.kind       = KIND_PAYLOAD;
                        fresh.frame_cmd  = held_cmd;
                        fresh.frame_len  = declared_len;
                        fresh.data_byte  = b;
                        fresh.data_index = payload_pos;
                        produced         = 1'b1;
                        running_crc      = crc8_next(running_crc, b);
                        if ({1'b0, payload_pos} + 9'd1 >= {1'b0, declared_len}) begin
                            phase = PH_CRC;
                        end
                        payload_pos = payload_pos + 8'd1;
                    end
                    PH_CRC: begin
                        if (b == running_crc) begin
                            good_count = good_count + 32'd1;
                            fresh.kind = KIND_GOOD;
                        end else begin
                            crc_err_count = crc_err_count + 32'd1;
                            fresh.kind    = KIND_CRC_ERR;
                        end
                        fresh.frame_cmd = held_cmd;
                        fresh.frame_len = declared_len;
                        produced        = 1'b1;
                        phase           = PH_HUNT0;
                    end
                    default: begin
                        phase = (b == SYNC_FIRST) ? PH_HUNT1 : PH_HUNT0;
                    end
                endcase
                if (produced) begin
                    fresh.good_total     = good_count;
                    fresh.crc_fail_total = crc_err_count;
                    expected_q.push_back(fresh);
                end
            end
        end
        o_pending    <= expected_q.size();
        o_fail_count <= mismatches;
    end

endmodule

>>> test/tb_framed_byte_receiver_crc8.sv
// Testbench top for framed_byte_receiver_crc8: drives directed and random
// frames, noise and broken headers under several length limits, with random
// gaps and stalls. Depends on fbr_pkg, the receiver RTL and fbr_checker.
module tb_framed_byte_receiver_crc8;
    timeunit 1ns;
    timeprecision 1ps;

    import fbr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BYTES    = 320;

    logic        clk;
    logic        rst_n;
    logic        rx_valid;
    logic        rx_stall;
    logic [7:0]  rx_byte;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        res_valid;
    logic        res_stall;
    logic [1:0]  res_kind;
    logic [7:0]  res_cmd;
    logic [7:0]  res_len;
    logic [7:0]  res_data;
    logic [7:0]  res_index;
    logic [31:0] res_good;
    logic [31:0] res_crc_fail;
    t_result     dut_result;

    int          pending_results;
    int          fail_count;
    int          quiet_cycles = 0;
    int          sent_count = 0;
    int          rx_burst_left = 0;
    int          res_burst_left = 0;
    logic [7:0]  max_len;
    logic [7:0]  limit_plan [0:4];

    framed_byte_receiver_crc8 dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (rx_valid),
        .o_stall          (rx_stall),
        .i_rx_byte        (rx_byte),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_wr_data    (cfg_wr_data),
        .o_valid          (res_valid),
        .i_stall          (res_stall),
        .o_kind           (res_kind),
        .o_frame_cmd      (res_cmd),
        .o_frame_len      (res_len),
        .o_data_byte      (res_data),
        .o_data_index     (res_index),
        .o_good_total     (res_good),
        .o_crc_fail_total (res_crc_fail)
    );

    assign dut_result = {res_kind, res_cmd, res_len, res_data, res_index, res_good, res_crc_fail};

    fbr_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_rx_valid    (rx_valid),
        .i_rx_stall    (rx_stall),
        .i_rx_byte     (rx_byte),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_res_valid   (res_valid),
        .i_res_stall   (res_stall),
        .i_result      (dut_result),
        .o_pending     (pending_results),
        .o_fail_count  (fail_count)
    );

    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_wait(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst_left = $urandom_range(10, 60);
        end
        return $urandom_range(0, 18);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_wait(rx_burst_left);
        if (gap > 0) begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (rx_stall);
        sent_count++;
    endtask

    task automatic send_frame(input logic [7:0] len, input logic [7:0] cmd,
                              input bit bad_crc, input int cut);
        logic [7:0] bytes_q[$];
        logic [7:0] crc;
        logic [7:0] d;
        bytes_q.push_back(SYNC_FIRST);
        bytes_q.push_back(SYNC_SECOND);
        bytes_q.push_back(len);
        bytes_q.push_back(cmd);
        crc = crc8_update(8'h00, len);
        crc = crc8_update(crc, cmd);
        for (int i = 0; i < len; i++) begin
            d = 8'($urandom_range(0, 255));
            bytes_q.push_back(d);
            crc = crc8_update(crc, d);
        end
        if (bad_crc) begin
            crc = crc ^ 8'($urandom_range(1, 255));
        end
        bytes_q.push_back(crc);
        if (len > max_len) begin
            cut = 3;
        end
        for (int i = 0; i < bytes_q.size() && i < cut; i++) begin
            send_byte(bytes_q[i]);
        end
    endtask

    task automatic write_limit(input logic [7:0] value);
        rx_valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
        repeat (3) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        max_len = value;
    endtask

    initial begin : result_drain
        int n;
        res_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            n = draw_wait(res_burst_left);
            if (n > 0) begin
                res_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            res_stall <= 1'b0;
            do @(posedge clk); while (!res_valid);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (rx_valid && !rx_stall) || (res_valid && !res_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int         start;
        int         r;
        int         pick;
        int         k;
        logic [7:0] len;
        logic [7:0] b;
        rst_n       = 1'b0;
        rx_valid    = 1'b0;
        rx_byte     = 8'h00;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 8'h00;
        max_len     = MAX_PAYLOAD_RESET;
        limit_plan[0] = 8'd0;
        limit_plan[1] = 8'd255;
        limit_plan[2] = 8'd5;
        limit_plan[3] = 8'($urandom_range(1, 254));
        limit_plan[4] = MAX_PAYLOAD_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send_frame(8'd0, 8'h00, 1'b0, 1000);
        send_frame(8'd1, 8'hFF, 1'b1, 1000);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_frame(8'd201, 8'h00, 1'b0, 1000);
        send_frame(8'd2, 8'h80, 1'b0, 1000);

        for (int p = 0; p < 5; p++) begin
            write_limit(limit_plan[p]);
            start = sent_count;
            while (sent_count - start < PHASE_BYTES) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    pick = $urandom_range(0, 39);
                    if (pick == 0 || (pick < 4 && max_len <= 16)) begin
                        len = max_len;
                    end else if (pick < 6 && max_len < 255) begin
                        len = 8'($urandom_range(max_len + 1, 255));
                    end else begin
                        len = 8'($urandom_range(0, max_len < 12 ? max_len : 12));
                    end
                    send_frame(len, 8'($urandom_range(0, 255)),
                               $urandom_range(0, 4) == 0, 1000);
                end else if (r < 85) begin
                    k = $urandom_range(1, 6);
                    repeat (k) send_byte(8'($urandom_range(0, 255)));
                end else if (r < 92) begin
                    send_byte(SYNC_FIRST);
                    b = 8'($urandom_range(0, 255));
                    if (b == SYNC_SECOND) begin
                        b = 8'h00;
                    end
                    send_byte(b);
                end else begin
                    len = 8'($urandom_range(0, max_len < 12 ? max_len : 12));
                    send_frame(len, 8'($urandom_range(0, 255)), 1'b0,
                               $urandom_range(3, len + 4));
                end
            end
        end

        rx_valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/fbr_pkg.sv
rtl/core/fbr_deframer.sv
rtl/core/fbr_out_stage.sv
rtl/core/framed_byte_receiver_crc8.sv
rtl/core/fbr_checker.sv
test/fbr_checker.sv
test/tb_framed_byte_receiver_crc8.sv
